FILE: hw/rtl/elrs_pkg.sv
`timescale 1ns / 1ps

package elrs_pkg;

    // item commands, carried in the input tuser
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_NEXT   = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_WALK_END = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_SECTOR_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_SECTORS = 2'd1;

    localparam logic [15:0] SECTOR_SIZE_RST     = 16'd512;
    localparam logic [7:0]  MAX_SECTORS_RST     = 8'd128;
    localparam logic [15:0] AUDIO_SECTOR_BYTES  = 16'd2352;

    localparam int SECTOR_W = 32;
    localparam int REQ_CNT_W = 8;
    localparam int OFFSET_W = 48;
    localparam int RUNS_W = 7;

endpackage

FILE: hw/rtl/elrs_ram.sv
`timescale 1ns / 1ps

module elrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/extent_list_request_splitter.sv
`timescale 1ns / 1ps

// flow: the request and its run table read (registered ram output) are registered
//   first, then the update and result register; a new request is taken only once
//   the result is registered, which waits while a held result is not yet taken
// reset: control state, sector sum, walk position and config return to defaults;
//   the run tables are not cleared and need no clearing pass

module extent_list_request_splitter
    import elrs_pkg::*;
#(
    parameter int RUN_ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // input requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // run start [31:0], sector_count [63:32]
    input  logic [1:0]   s_tuser,   // cmd [1:0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // req start [31:0], req_sector_count [39:32],
                                    // byte_offset [87:40], runs_stored [94:88],
                                    // total_sectors [126:95], zero [127]
    output logic [2:0]   m_tuser,   // status [1:0], audio_path [2]
    output logic         m_tlast,   // final_request
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int IDX_W = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
    localparam int CNT_W = $clog2(RUN_ENTRIES + 1);

    // control state
    logic                 busy_reg;
    logic                 out_valid_reg;
    logic [CNT_W-1:0]     run_total_reg,  run_total_next;
    logic [CNT_W-1:0]     walk_run_reg,   walk_run_next;
    logic [SECTOR_W-1:0]  walk_off_reg,   walk_off_next;
    logic [SECTOR_W-1:0]  sectors_done_reg, sectors_done_next;
    logic [SECTOR_W-1:0]  sector_sum_reg, sector_sum_next;
    logic [15:0]          sector_size_reg;
    logic [7:0]           max_sectors_reg;

    // item register
    cmd_t                 cmd_reg;
    logic [SECTOR_W-1:0]  first_reg;
    logic [SECTOR_W-1:0]  count_reg;

    // result register
    status_t              status_reg,    status_next;
    logic [SECTOR_W-1:0]  req_first_reg, req_first_next;
    logic [REQ_CNT_W-1:0] req_cnt_reg,   req_cnt_next;
    logic [OFFSET_W-1:0]  offset_reg,    offset_next;
    logic                 final_reg,     final_next;
    logic                 audio_reg,     audio_next;
    logic [RUNS_W-1:0]    runs_reg,      runs_next;
    logic [SECTOR_W-1:0]  total_reg;

    // table ports
    logic                 tbl_wr_start, tbl_wr_len;
    logic [IDX_W-1:0]     tbl_wr_addr;
    logic [SECTOR_W-1:0]  tbl_wr_len_data;
    logic [IDX_W-1:0]     tbl_rd_addr;
    logic [SECTOR_W-1:0]  start_rd, len_rd;

    logic                 accept;
    logic                 fire;
    cmd_t                 in_cmd;
    logic [CNT_W-1:0]     run_last;

    logic [32:0]          sum_ext;
    logic [32:0]          end_ext;
    logic [SECTOR_W-1:0]  remain;
    logic [REQ_CNT_W-1:0] limit;
    logic [REQ_CNT_W-1:0] n_cnt;
    logic [SECTOR_W-1:0]  new_off;
    logic [CNT_W-1:0]     walk_inc;
    logic [CNT_W+RUNS_W-1:0] runs_wide;

    assign in_cmd    = cmd_t'(s_tuser);
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign fire      = busy_reg && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // table read address chosen at accept: last run for add, walk run for next
    assign run_last    = run_total_reg - CNT_W'(1);
    assign tbl_rd_addr = (in_cmd == CMD_NEXT) ? walk_run_reg[IDX_W-1:0]
                                              : run_last[IDX_W-1:0];

    elrs_ram #(.WIDTH(SECTOR_W), .DEPTH(RUN_ENTRIES)) u_start_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_start),
        .wr_addr (tbl_wr_addr),
        .wr_data (first_reg),
        .rd_en   (accept),
        .rd_addr (tbl_rd_addr),
        .rd_data (start_rd)
    );

    elrs_ram #(.WIDTH(SECTOR_W), .DEPTH(RUN_ENTRIES)) u_len_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_len),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_len_data),
        .rd_en   (accept),
        .rd_addr (tbl_rd_addr),
        .rd_data (len_rd)
    );

    // shared arithmetic for add and next
    assign sum_ext  = {1'b0, sector_sum_reg} + {1'b0, count_reg};
    assign end_ext  = {1'b0, start_rd} + {1'b0, len_rd};
    assign remain   = len_rd - walk_off_reg;
    assign limit    = (max_sectors_reg == '0) ? REQ_CNT_W'(1) : max_sectors_reg;
    assign n_cnt    = (remain < {24'b0, limit}) ? remain[REQ_CNT_W-1:0] : limit;
    assign new_off  = walk_off_reg + {24'b0, n_cnt};
    assign walk_inc = walk_run_reg + CNT_W'(1);

    // item evaluation and state update
    always_comb
    begin
        run_total_next    = run_total_reg;
        walk_run_next     = walk_run_reg;
        walk_off_next     = walk_off_reg;
        sectors_done_next = sectors_done_reg;
        sector_sum_next   = sector_sum_reg;
        status_next       = ST_OK;
        req_first_next    = '0;
        req_cnt_next      = '0;
        offset_next       = '0;
        final_next        = 1'b0;
        tbl_wr_start      = 1'b0;
        tbl_wr_len        = 1'b0;
        tbl_wr_addr       = run_total_reg[IDX_W-1:0];
        tbl_wr_len_data   = count_reg;

        unique case (cmd_reg)
            CMD_ADD:
            begin
                priority if (count_reg == '0)
                begin
                    status_next = ST_OK;
                end
                else if (sum_ext[32])
                begin
                    status_next = ST_OVERFLOW;
                end
                else if (run_total_reg != '0 && end_ext == {1'b0, first_reg})
                begin
                    // coalesce with the last run
                    tbl_wr_len      = fire;
                    tbl_wr_addr     = run_last[IDX_W-1:0];
                    tbl_wr_len_data = len_rd + count_reg;
                    sector_sum_next = sum_ext[31:0];
                end
                else if (run_total_reg >= CNT_W'(RUN_ENTRIES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // append a new run
                    tbl_wr_start    = fire;
                    tbl_wr_len      = fire;
                    run_total_next  = run_total_reg + CNT_W'(1);
                    sector_sum_next = sum_ext[31:0];
                end
            end
            CMD_NEXT:
            begin
                if (walk_run_reg >= run_total_reg)
                begin
                    status_next = ST_WALK_END;
                end
                else
                begin
                    req_first_next    = start_rd + walk_off_reg;
                    req_cnt_next      = n_cnt;
                    offset_next       = {16'b0, sectors_done_reg} * {32'b0, sector_size_reg};
                    sectors_done_next = sectors_done_reg + {24'b0, n_cnt};
                    walk_off_next     = new_off;
                    if (new_off >= len_rd)
                    begin
                        walk_run_next = walk_inc;
                        walk_off_next = '0;
                        final_next    = (walk_inc == run_total_reg);
                    end
                end
            end
            CMD_REWIND:
            begin
                walk_run_next     = '0;
                walk_off_next     = '0;
                sectors_done_next = '0;
            end
            CMD_CLEAR:
            begin
                run_total_next    = '0;
                sector_sum_next   = '0;
                walk_run_next     = '0;
                walk_off_next     = '0;
                sectors_done_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        audio_next = (sector_size_reg == AUDIO_SECTOR_BYTES);
        runs_wide  = {{RUNS_W{1'b0}}, run_total_next};
        runs_next  = runs_wide[RUNS_W-1:0];
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            run_total_reg    <= '0;
            walk_run_reg     <= '0;
            walk_off_reg     <= '0;
            sectors_done_reg <= '0;
            sector_sum_reg   <= '0;
            sector_size_reg  <= SECTOR_SIZE_RST;
            max_sectors_reg  <= MAX_SECTORS_RST;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire)
            begin
                busy_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg    <= 1'b1;
                run_total_reg    <= run_total_next;
                walk_run_reg     <= walk_run_next;
                walk_off_reg     <= walk_off_next;
                sectors_done_reg <= sectors_done_next;
                sector_sum_reg   <= sector_sum_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_SECTOR_SIZE)
                begin
                    sector_size_reg <= cfg_data;
                end
                else if (cfg_index == CFG_MAX_SECTORS)
                begin
                    max_sectors_reg <= cfg_data[7:0];
                end
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            first_reg <= s_tdata[31:0];
            count_reg <= s_tdata[63:32];
        end
        if (fire)
        begin
            status_reg    <= status_next;
            req_first_reg <= req_first_next;
            req_cnt_reg   <= req_cnt_next;
            offset_reg    <= offset_next;
            final_reg     <= final_next;
            audio_reg     <= audio_next;
            runs_reg      <= runs_next;
            total_reg     <= sector_sum_next;
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, total_reg, runs_reg, offset_reg, req_cnt_reg, req_first_reg};
    assign m_tuser  = {audio_reg, status_reg};
    assign m_tlast  = final_reg;

endmodule
